@@ design/mck_pkg.sv @@
// ----------------------------------------------------------------------------
// Morse character keyer package
// Shared types, register codes and the symbol table lookup.
// ----------------------------------------------------------------------------
package mck_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int MAX_ELEMENTS        = 5;
   localparam int UNITS_WIDTH         = 4;
   localparam int CSR_INDEX_WIDTH     = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DIT_UNITS         = 3'd0,
      CSR_DAH_UNITS         = 3'd1,
      CSR_ELEMENT_GAP_UNITS = 3'd2,
      CSR_LETTER_GAP_UNITS  = 3'd3,
      CSR_WORD_GAP_UNITS    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [UNITS_WIDTH-1:0] dit_units;
      logic [UNITS_WIDTH-1:0] dah_units;
      logic [UNITS_WIDTH-1:0] element_gap_units;
      logic [UNITS_WIDTH-1:0] letter_gap_units;
      logic [UNITS_WIDTH-1:0] word_gap_units;
   } cfg_type;

   // The pattern is left aligned: the next element is in the top bit, 1 = dit.
   typedef struct packed {
      logic                    is_space;
      logic [2:0]              elem_count;
      logic [MAX_ELEMENTS-1:0] pattern;
   } symbol_type;

   typedef struct packed {
      logic       valid;
      symbol_type symbol;
   } lookup_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_MARK,
      SEQ_GAP,
      SEQ_LETTER
   } seq_state_type;

   function automatic lookup_type lookup_symbol(input logic [7:0] char_code);
      lookup_type result;
      logic [2:0] len_v;
      logic [7:0] bits_v;
      result = '0;
      len_v  = 3'd0;
      bits_v = 8'h00;
      unique case (char_code)
         8'h61: begin len_v = 3'd2; bits_v = 8'h06; end
         8'h62: begin len_v = 3'd4; bits_v = 8'h17; end
         8'h63: begin len_v = 3'd4; bits_v = 8'h15; end
         8'h64: begin len_v = 3'd3; bits_v = 8'h0b; end
         8'h65: begin len_v = 3'd1; bits_v = 8'h03; end
         8'h66: begin len_v = 3'd4; bits_v = 8'h1d; end
         8'h68: begin len_v = 3'd4; bits_v = 8'h1f; end
         8'h69: begin len_v = 3'd2; bits_v = 8'h07; end
         8'h6a: begin len_v = 3'd4; bits_v = 8'h18; end
         8'h6b: begin len_v = 3'd3; bits_v = 8'h0a; end
         8'h6c: begin len_v = 3'd4; bits_v = 8'h1b; end
         8'h6d: begin len_v = 3'd2; bits_v = 8'h04; end
         8'h6e: begin len_v = 3'd2; bits_v = 8'h05; end
         8'h6f: begin len_v = 3'd3; bits_v = 8'h08; end
         8'h70: begin len_v = 3'd4; bits_v = 8'h19; end
         8'h71: begin len_v = 3'd4; bits_v = 8'h12; end
         8'h72: begin len_v = 3'd3; bits_v = 8'h0d; end
         8'h73: begin len_v = 3'd3; bits_v = 8'h0f; end
         8'h74: begin len_v = 3'd1; bits_v = 8'h02; end
         8'h75: begin len_v = 3'd3; bits_v = 8'h0e; end
         8'h77: begin len_v = 3'd3; bits_v = 8'h0c; end
         8'h79: begin len_v = 3'd4; bits_v = 8'h14; end
         8'h2f: begin len_v = 3'd5; bits_v = 8'h2d; end
         8'h30: begin len_v = 3'd5; bits_v = 8'h20; end
         8'h31: begin len_v = 3'd5; bits_v = 8'h30; end
         8'h32: begin len_v = 3'd5; bits_v = 8'h38; end
         8'h33: begin len_v = 3'd5; bits_v = 8'h3c; end
         8'h34: begin len_v = 3'd5; bits_v = 8'h3e; end
         8'h35: begin len_v = 3'd5; bits_v = 8'h3f; end
         8'h36: begin len_v = 3'd5; bits_v = 8'h2f; end
         8'h37: begin len_v = 3'd5; bits_v = 8'h27; end
         8'h38: begin len_v = 3'd5; bits_v = 8'h23; end
         8'h39: begin len_v = 3'd5; bits_v = 8'h21; end
         8'h20: begin
            result.valid           = 1'b1;
            result.symbol.is_space = 1'b1;
         end
         default: begin
            len_v = 3'd0;
         end
      endcase
      if (len_v != 3'd0) begin
         result.valid             = 1'b1;
         result.symbol.elem_count = len_v;
         // Shifting left drops the marker bit above the first element.
         result.symbol.pattern    =
            MAX_ELEMENTS'(bits_v << (3'(MAX_ELEMENTS) - len_v));
      end
      return result;
   endfunction

endpackage

@@ design/mck_front.sv @@
// ----------------------------------------------------------------------------
// Morse keyer front end
// Accepts characters, looks them up and queues the symbols that key something.
// ----------------------------------------------------------------------------
module mck_front (
   input  logic                req_push,
   input  logic [7:0]          req_char_code,
   input  logic                queue_full,
   output logic                req_full,
   output logic                queue_push,
   output mck_pkg::symbol_type queue_data
);

   mck_pkg::lookup_type lookup;

   always_comb begin
      lookup = mck_pkg::lookup_symbol(req_char_code);
   end

   // Characters outside the table are taken and dropped.
   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full && lookup.valid;
   assign queue_data = lookup.symbol;

endmodule

@@ design/mck_queue.sv @@
// ----------------------------------------------------------------------------
// Morse keyer symbol queue
// A short register FIFO between the front end and the sequencer.
// ----------------------------------------------------------------------------
module mck_queue #(
   parameter int DEPTH = mck_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mck_pkg::symbol_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output mck_pkg::symbol_type pop_data
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   mck_pkg::symbol_type       entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      do_push, do_pop;

   assign full     = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/mck_back.sv @@
// ----------------------------------------------------------------------------
// Morse keyer sequencer
// Steps through the elements of a queued symbol and issues key segments.
// ----------------------------------------------------------------------------
module mck_back (
   input  logic                clock,
   input  logic                reset,
   input  mck_pkg::cfg_type    cfg,
   input  logic                queue_empty,
   input  mck_pkg::symbol_type queue_data,
   output logic                queue_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_key_down,
   output logic [3:0]          rsp_duration_units,
   output logic                rsp_last_segment
);

   mck_pkg::seq_state_type               state_ff, state_in;
   logic [mck_pkg::MAX_ELEMENTS-1:0]     pattern_ff, pattern_in;
   logic [2:0]                           remain_ff, remain_in;
   logic                                 out_valid_ff, out_valid_in;
   logic                                 out_key_ff, out_key_in;
   logic [mck_pkg::UNITS_WIDTH-1:0]      out_dur_ff, out_dur_in;
   logic                                 out_last_ff, out_last_in;
   logic                                 advance;
   logic                                 emit;

   // The result register can take a new segment when it is free or being read.
   assign advance = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in   = state_ff;
      pattern_in = pattern_ff;
      remain_in  = remain_ff;
      if (advance) begin
         unique case (state_ff)
            mck_pkg::SEQ_IDLE: begin
               if (!queue_empty && !queue_data.is_space) begin
                  pattern_in = queue_data.pattern;
                  remain_in  = queue_data.elem_count;
                  state_in   = mck_pkg::SEQ_MARK;
               end
            end
            mck_pkg::SEQ_MARK: begin
               state_in = mck_pkg::SEQ_GAP;
            end
            mck_pkg::SEQ_GAP: begin
               pattern_in = {pattern_ff[mck_pkg::MAX_ELEMENTS-2:0], 1'b0};
               remain_in  = remain_ff - 1'b1;
               state_in   = (remain_ff == 3'd1) ? mck_pkg::SEQ_LETTER : mck_pkg::SEQ_MARK;
            end
            mck_pkg::SEQ_LETTER: begin
               state_in = mck_pkg::SEQ_IDLE;
            end
            default: begin
               state_in = mck_pkg::SEQ_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      queue_pop   = 1'b0;
      emit        = 1'b0;
      out_key_in  = out_key_ff;
      out_dur_in  = out_dur_ff;
      out_last_in = out_last_ff;
      if (advance) begin
         unique case (state_ff)
            mck_pkg::SEQ_IDLE: begin
               queue_pop = !queue_empty;
               if (!queue_empty && queue_data.is_space) begin
                  emit        = 1'b1;
                  out_key_in  = 1'b0;
                  out_dur_in  = cfg.word_gap_units;
                  out_last_in = 1'b1;
               end
            end
            mck_pkg::SEQ_MARK: begin
               emit        = 1'b1;
               out_key_in  = 1'b1;
               out_dur_in  = pattern_ff[mck_pkg::MAX_ELEMENTS-1] ? cfg.dit_units
                                                                 : cfg.dah_units;
               out_last_in = 1'b0;
            end
            mck_pkg::SEQ_GAP: begin
               emit        = 1'b1;
               out_key_in  = 1'b0;
               out_dur_in  = cfg.element_gap_units;
               out_last_in = 1'b0;
            end
            mck_pkg::SEQ_LETTER: begin
               emit        = 1'b1;
               out_key_in  = 1'b0;
               out_dur_in  = cfg.letter_gap_units;
               out_last_in = 1'b1;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mck_pkg::SEQ_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff  <= pattern_in;
      remain_ff   <= remain_in;
      out_key_ff  <= out_key_in;
      out_dur_ff  <= out_dur_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_key_down       = out_key_ff;
   assign rsp_duration_units = out_dur_ff;
   assign rsp_last_segment   = out_last_ff;

endmodule

@@ design/morse_character_keyer.sv @@
// ----------------------------------------------------------------------------
// Morse character keyer
// Turns ASCII characters into runs of key segments (level and duration).
// ----------------------------------------------------------------------------
// Requests enter through req_push / req_full, one character each. Characters
// outside the symbol table are accepted and produce nothing. Segments leave
// through rsp_empty / rsp_pop, oldest first; the final segment of each
// character has rsp_last_segment set.
// Timing: a space's single segment passes through the queue and then straight
// into the result register. A letter of L elements passes through the queue and
// the sequencer state, then yields one segment a cycle while the receiver keeps
// up, 2L+1 segments per character, as the sequencer steps one element phase per cycle.
// A short symbol queue lets the next requests be taken while the sequencer
// works; req_full rises only once that queue is full.
// When the receiver stalls, the pending segment holds in the result register
// and the sequencer waits. Timing registers are written on csr_we and read
// live by the sequencer. Reset empties the queue and the result register and
// loads the default timing of 1, 3, 1, 3 and 7 units.
// ----------------------------------------------------------------------------
module morse_character_keyer #(
   parameter int QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [7:0]                          req_char_code,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_key_down,
   output logic [3:0]                          rsp_duration_units,
   output logic                                rsp_last_segment,
   input  logic                                csr_we,
   input  logic [mck_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mck_pkg::UNITS_WIDTH-1:0]     csr_wdata
);

   mck_pkg::cfg_type    cfg_ff, cfg_in;
   mck_pkg::symbol_type push_data;
   mck_pkg::symbol_type head_data;
   logic                queue_push;
   logic                queue_pop;
   logic                queue_full;
   logic                queue_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            mck_pkg::CSR_DIT_UNITS:         cfg_in.dit_units         = csr_wdata;
            mck_pkg::CSR_DAH_UNITS:         cfg_in.dah_units         = csr_wdata;
            mck_pkg::CSR_ELEMENT_GAP_UNITS: cfg_in.element_gap_units = csr_wdata;
            mck_pkg::CSR_LETTER_GAP_UNITS:  cfg_in.letter_gap_units  = csr_wdata;
            mck_pkg::CSR_WORD_GAP_UNITS:    cfg_in.word_gap_units    = csr_wdata;
            default:                        cfg_in                   = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dit_units         <= 4'd1;
         cfg_ff.dah_units         <= 4'd3;
         cfg_ff.element_gap_units <= 4'd1;
         cfg_ff.letter_gap_units  <= 4'd3;
         cfg_ff.word_gap_units    <= 4'd7;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mck_front u_front (
      .req_push      (req_push),
      .req_char_code (req_char_code),
      .queue_full    (queue_full),
      .req_full      (req_full),
      .queue_push    (queue_push),
      .queue_data    (push_data)
   );

   mck_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .pop       (queue_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .pop_data  (head_data)
   );

   mck_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .queue_empty        (queue_empty),
      .queue_data         (head_data),
      .queue_pop          (queue_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_key_down       (rsp_key_down),
      .rsp_duration_units (rsp_duration_units),
      .rsp_last_segment   (rsp_last_segment)
   );

endmodule

@@ tb/morse_character_keyer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse character keyer testbench
// Sends ASCII characters into the keyer and checks every key segment that
// comes back. A hand-written table starts the run from the default timing,
// with typed-in segments for the obvious cases. Random phases follow with
// fresh timing each time, including all-zero and all-fifteen, and with
// different amounts of idling on both sides. One phase holds the segment
// side off for a long stretch so that the request side backs up. Expected
// segments come from the testbench's own Morse table and timing copy.
// ----------------------------------------------------------------------------
module morse_character_keyer_test;

   localparam int         CSR_INDEX_COUNT   = 5;
   localparam logic [7:0] SPACE_CODE        = 8'h20;
   localparam byte        DIT_MARK          = ".";
   localparam int         SETTLE_CYCLES     = 40;
   localparam int         LONG_STALL_CYCLES = 250;
   localparam int         RANDOM_PHASES     = 8;
   localparam int         PHASE_CHARS       = 34;
   localparam int         PRESSURE_CHARS    = 20;
   localparam int         MAX_REPORTS       = 10;
   localparam int         DIRECTED_COUNT    = 20;

   localparam int SEND_IDLE_PCT [4] = '{0, 65, 0, 19};
   localparam int POP_STALL_PCT [4] = '{0, 0, 65, 19};

   typedef logic [mck_pkg::CSR_INDEX_WIDTH-1:0] csr_index_bits_type;
   typedef logic [mck_pkg::UNITS_WIDTH-1:0]     units_type;

   typedef struct packed {
      logic       key_down;
      logic [3:0] duration_units;
      logic       last_segment;
   } segment_type;

   typedef struct packed {
      logic [7:0]         char_code;
      logic               typed;
      logic [1:0]         count;
      segment_type [0:2]  segs;
   } directed_row_type;

   localparam segment_type NO_SEG = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_char_code = 8'h00;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic               rsp_key_down;
   logic [3:0]         rsp_duration_units;
   logic               rsp_last_segment;
   logic               csr_we = 1'b0;
   csr_index_bits_type csr_index = '0;
   units_type          csr_wdata = '0;

   mck_pkg::cfg_type timing = '{dit_units: 4'd1, dah_units: 4'd3,
                                element_gap_units: 4'd1, letter_gap_units: 4'd3,
                                word_gap_units: 4'd7};
   segment_type expected_segments [$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          pop_stall_pct = 0;
   int          long_stalls_asked = 0;
   int          long_stalls_done = 0;
   string       symbol_chars = "abcdefhijklmnopqrstuwy/0123456789 ";

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{SPACE_CODE, 1'b1, 2'd1, {segment_type'{1'b0, 4'd7, 1'b1}, NO_SEG, NO_SEG}},
      '{"e", 1'b1, 2'd3, {segment_type'{1'b1, 4'd1, 1'b0},
                          segment_type'{1'b0, 4'd1, 1'b0},
                          segment_type'{1'b0, 4'd3, 1'b1}}},
      '{"t", 1'b1, 2'd3, {segment_type'{1'b1, 4'd3, 1'b0},
                          segment_type'{1'b0, 4'd1, 1'b0},
                          segment_type'{1'b0, 4'd3, 1'b1}}},
      '{8'h00, 1'b1, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{8'hff, 1'b1, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"G", 1'b1, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"g", 1'b1, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"v", 1'b1, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"x", 1'b1, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"z", 1'b1, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"A", 1'b1, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"5", 1'b0, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"0", 1'b0, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"/", 1'b0, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"a", 1'b0, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"q", 1'b0, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"y", 1'b0, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"9", 1'b0, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{"h", 1'b0, 2'd0, {NO_SEG, NO_SEG, NO_SEG}},
      '{SPACE_CODE, 1'b1, 2'd1, {segment_type'{1'b0, 4'd7, 1'b1}, NO_SEG, NO_SEG}}
   };

   morse_character_keyer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_char_code      (req_char_code),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_key_down       (rsp_key_down),
      .rsp_duration_units (rsp_duration_units),
      .rsp_last_segment   (rsp_last_segment),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic string morse_pattern(input logic [7:0] ch);
      case (ch)
         "a": return ".-";
         "b": return "-...";
         "c": return "-.-.";
         "d": return "-..";
         "e": return ".";
         "f": return "..-.";
         "h": return "....";
         "i": return "..";
         "j": return ".---";
         "k": return "-.-";
         "l": return ".-..";
         "m": return "--";
         "n": return "-.";
         "o": return "---";
         "p": return ".--.";
         "q": return "--.-";
         "r": return ".-.";
         "s": return "...";
         "t": return "-";
         "u": return "..-";
         "w": return ".--";
         "y": return "-.--";
         "/": return "-..-.";
         "0": return "-----";
         "1": return ".----";
         "2": return "..---";
         "3": return "...--";
         "4": return "....-";
         "5": return ".....";
         "6": return "-....";
         "7": return "--...";
         "8": return "---..";
         "9": return "----.";
         default: return "";
      endcase
   endfunction

   // Queues the segments of one accepted character and returns how many.
   function automatic int queue_character_segments(input logic [7:0] ch);
      string pattern;
      int    n;
      n = 0;
      if (ch == SPACE_CODE) begin
         expected_segments.push_back(segment_type'{1'b0, timing.word_gap_units, 1'b1});
         n = 1;
      end else begin
         pattern = morse_pattern(ch);
         if (pattern.len() != 0) begin
            for (int i = 0; i < pattern.len(); i++) begin
               expected_segments.push_back(segment_type'{1'b1,
                  (pattern[i] == DIT_MARK) ? timing.dit_units : timing.dah_units, 1'b0});
               expected_segments.push_back(
                  segment_type'{1'b0, timing.element_gap_units, 1'b0});
            end
            expected_segments.push_back(segment_type'{1'b0, timing.letter_gap_units, 1'b1});
            n = 2 * pattern.len() + 1;
         end
      end
      return n;
   endfunction

   function automatic void note_mismatch(input string what, input segment_type want,
                                         input segment_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s: expected key %0d units %0d last %0d, got key %0d units %0d last %0d",
                  $realtime, what, want.key_down, want.duration_units, want.last_segment,
                  got.key_down, got.duration_units, got.last_segment);
      end
   endfunction

   always @(posedge clock) begin : segment_monitor
      segment_type got;
      segment_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = segment_type'{rsp_key_down, rsp_duration_units, rsp_last_segment};
         if (expected_segments.size() == 0) begin
            note_mismatch("segment with no request behind it", NO_SEG, got);
         end else begin
            want = expected_segments.pop_front();
            if (got.key_down !== want.key_down
                || got.duration_units !== want.duration_units
                || got.last_segment !== want.last_segment) begin
               note_mismatch("segment mismatch", want, got);
            end
         end
      end
   end

   initial begin : segment_receiver
      forever begin
         @(posedge clock);
         if (long_stalls_done != long_stalls_asked) begin
            long_stalls_done = long_stalls_asked;
            rsp_pop <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
         end
      end
   end

   task automatic send_char(input logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push      <= 1'b0;
         req_char_code <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_char_code <= ch;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_bits_type idx, input units_type value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         mck_pkg::CSR_DIT_UNITS:         timing.dit_units = value;
         mck_pkg::CSR_DAH_UNITS:         timing.dah_units = value;
         mck_pkg::CSR_ELEMENT_GAP_UNITS: timing.element_gap_units = value;
         mck_pkg::CSR_LETTER_GAP_UNITS:  timing.letter_gap_units = value;
         mck_pkg::CSR_WORD_GAP_UNITS:    timing.word_gap_units = value;
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [3:0] dit, input logic [3:0] dah,
                             input logic [3:0] element_gap, input logic [3:0] letter_gap,
                             input logic [3:0] word_gap);
      write_csr(mck_pkg::CSR_DIT_UNITS, dit);
      write_csr(mck_pkg::CSR_DAH_UNITS, dah);
      write_csr(mck_pkg::CSR_ELEMENT_GAP_UNITS, element_gap);
      write_csr(mck_pkg::CSR_LETTER_GAP_UNITS, letter_gap);
      write_csr(mck_pkg::CSR_WORD_GAP_UNITS, word_gap);
   endtask

   // Lets the keyer finish every queued segment and any character that yields none.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_chars(input int goal);
      logic [7:0] ch;
      for (int n = 0; n < goal; n++) begin
         if ($urandom_range(99) < 75) begin
            ch = symbol_chars[$urandom_range(symbol_chars.len() - 1)];
         end else begin
            ch = 8'($urandom_range(255));
         end
         send_char(ch);
         void'(queue_character_segments(ch));
      end
   endtask

   initial begin : stimulus
      directed_row_type row;
      int               mode;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_char(row.char_code);
         if (row.typed) begin
            for (int k = 0; k < row.count; k++) expected_segments.push_back(row.segs[k]);
         end else begin
            void'(queue_character_segments(row.char_code));
         end
      end
      wait_idle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: set_timing(4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
            1: set_timing(4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
            2: set_timing(4'd1, 4'd1, 4'd1, 4'd1, 4'd1);
            default: begin
               set_timing(4'($urandom_range(15)), 4'($urandom_range(15)),
                          4'($urandom_range(15)), 4'($urandom_range(15)),
                          4'($urandom_range(15)));
            end
         endcase
         if (ph == 3) begin
            for (int k = CSR_INDEX_COUNT; k < (1 << mck_pkg::CSR_INDEX_WIDTH); k++) begin
               write_csr(csr_index_bits_type'(k), 4'($urandom_range(15)));
            end
         end
         mode = ph % 4;
         send_idle_pct = SEND_IDLE_PCT[mode];
         pop_stall_pct = POP_STALL_PCT[mode];
         send_random_chars(PHASE_CHARS);
         wait_idle();
      end

      // The receiver goes quiet while requests keep coming, so the input backs up.
      set_timing(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)),
                 4'($urandom_range(15)), 4'($urandom_range(15)));
      send_idle_pct = 0;
      pop_stall_pct = 0;
      long_stalls_asked++;
      send_random_chars(PRESSURE_CHARS);
      wait_idle();

      if (mismatch_count == 0 && expected_segments.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : run_limit
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
